[sv/mi3_pkg.sv]
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants of the 3x3 matrix inverse
// Field widths, internal datapath widths, and the words that pass between
// the determinant front end, the divider lanes and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mi3_pkg;

   // element format: signed Q16.16
   localparam int DW   = 32;
   localparam int FB   = 16;
   // 2x2 minor product, cofactor, det partial term, determinant
   localparam int PW   = 2 * DW;
   localparam int CW   = 2 * DW + 1;
   localparam int TW   = 3 * DW + 1;
   localparam int DETW = 3 * DW + 3;
   // divider: numerator |cof| << 2*FB, quotient bits, remainder width
   localparam int NW   = CW + 2 * FB;
   localparam int QB   = DW + 1;
   localparam int RW   = DETW + QB;

   typedef struct packed {
      logic signed [DW-1:0] a00;
      logic signed [DW-1:0] a01;
      logic signed [DW-1:0] a02;
      logic signed [DW-1:0] a10;
      logic signed [DW-1:0] a11;
      logic signed [DW-1:0] a12;
      logic signed [DW-1:0] a20;
      logic signed [DW-1:0] a21;
      logic signed [DW-1:0] a22;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] inv00;
      logic signed [DW-1:0] inv01;
      logic signed [DW-1:0] inv02;
      logic signed [DW-1:0] inv10;
      logic signed [DW-1:0] inv11;
      logic signed [DW-1:0] inv12;
      logic signed [DW-1:0] inv20;
      logic signed [DW-1:0] inv21;
      logic signed [DW-1:0] inv22;
      logic                 singular;
      logic                 saturated;
   } rsp_type;

   // determinant summary leaving the front end
   typedef struct packed {
      logic            valid;
      logic            singular;
      logic [DETW-1:0] mag;
   } det_type;

   // one cofactor ready for division
   typedef struct packed {
      logic          neg;
      logic [NW-1:0] num;
   } lane_type;

   // one inverse element leaving a divider lane
   typedef struct packed {
      logic          valid;
      logic          singular;
      logic          sat;
      logic [DW-1:0] value;
   } lane_out_type;

   // state carried down the divider pipeline
   typedef struct packed {
      logic            valid;
      logic            singular;
      logic            neg;
      logic            ovf;
      logic [DETW-1:0] mag;
      logic [RW-1:0]   rem;
      logic [QB-1:0]   quo;
   } div_type;

endpackage

`default_nettype wire

[sv/mi3_det.sv]
// ----------------------------------------------------------------------------
// mi3_det: cofactor and determinant front end
// Seven register stages: minor products, cofactors, split products of row 0
// against its cofactors, partial terms, determinant, magnitudes, singular test.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_det
   import mi3_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire req_type in_data,
   input  wire logic [31:0] det_min,
   output det_type      det_out,
   output lane_type     lane_out [0:8]
);

   // operands of the 18 minor products, two per cofactor
   logic signed [DW-1:0] opx [0:17];
   logic signed [DW-1:0] opy [0:17];

   always_comb begin
      opx[0]  = in_data.a11; opy[0]  = in_data.a22;
      opx[1]  = in_data.a21; opy[1]  = in_data.a12;
      opx[2]  = in_data.a21; opy[2]  = in_data.a02;
      opx[3]  = in_data.a01; opy[3]  = in_data.a22;
      opx[4]  = in_data.a01; opy[4]  = in_data.a12;
      opx[5]  = in_data.a11; opy[5]  = in_data.a02;
      opx[6]  = in_data.a20; opy[6]  = in_data.a12;
      opx[7]  = in_data.a10; opy[7]  = in_data.a22;
      opx[8]  = in_data.a00; opy[8]  = in_data.a22;
      opx[9]  = in_data.a20; opy[9]  = in_data.a02;
      opx[10] = in_data.a10; opy[10] = in_data.a02;
      opx[11] = in_data.a00; opy[11] = in_data.a12;
      opx[12] = in_data.a10; opy[12] = in_data.a21;
      opx[13] = in_data.a20; opy[13] = in_data.a11;
      opx[14] = in_data.a20; opy[14] = in_data.a01;
      opx[15] = in_data.a00; opy[15] = in_data.a21;
      opx[16] = in_data.a00; opy[16] = in_data.a11;
      opx[17] = in_data.a10; opy[17] = in_data.a01;
   end

   // stage 1: minor products
   logic                 v1_ff;
   logic signed [PW-1:0] pp_ff [0:17];
   logic signed [DW-1:0] row1_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= in_valid;
   end

   for (genvar k = 0; k < 18; k++) begin : g_minor
      always_ff @(posedge clock) begin
         pp_ff[k] <= opx[k] * opy[k];
      end
   end

   always_ff @(posedge clock) begin
      row1_ff[0] <= in_data.a00;
      row1_ff[1] <= in_data.a01;
      row1_ff[2] <= in_data.a02;
   end

   // stage 2: cofactors (adjugate order)
   logic                 v2_ff;
   logic signed [CW-1:0] cof2_ff [0:8];
   logic signed [DW-1:0] row2_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
   end

   for (genvar k = 0; k < 9; k++) begin : g_cof
      always_ff @(posedge clock) begin
         cof2_ff[k] <= {pp_ff[2*k][PW-1], pp_ff[2*k]}
                     - {pp_ff[2*k+1][PW-1], pp_ff[2*k+1]};
      end
   end

   always_ff @(posedge clock) begin
      row2_ff <= row1_ff;
   end

   // stage 3: row 0 times its cofactors, split in low and high halves
   logic                 v3_ff;
   logic signed [CW-1:0] cof3_ff [0:8];
   logic signed [CW-1:0] plo_ff [0:2];
   logic signed [CW-1:0] phi_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
   end

   // det = a00*c00 + a01*c10 + a02*c20
   for (genvar k = 0; k < 3; k++) begin : g_split
      always_ff @(posedge clock) begin
         plo_ff[k] <= row2_ff[k] * $signed({1'b0, cof2_ff[3*k][DW-1:0]});
         phi_ff[k] <= row2_ff[k] * $signed(cof2_ff[3*k][CW-1:DW]);
      end
   end

   always_ff @(posedge clock) begin
      cof3_ff <= cof2_ff;
   end

   // stage 4: recombine halves
   logic                 v4_ff;
   logic signed [CW-1:0] cof4_ff [0:8];
   logic signed [TW-1:0] term_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3_ff;
   end

   for (genvar k = 0; k < 3; k++) begin : g_term
      always_ff @(posedge clock) begin
         term_ff[k] <= {phi_ff[k], {DW{1'b0}}}
                     + {{(TW-CW){plo_ff[k][CW-1]}}, plo_ff[k]};
      end
   end

   always_ff @(posedge clock) begin
      cof4_ff <= cof3_ff;
   end

   // stage 5: determinant
   logic                   v5_ff;
   logic signed [CW-1:0]   cof5_ff [0:8];
   logic signed [DETW-1:0] det5_ff;

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else       v5_ff <= v4_ff;
   end

   always_ff @(posedge clock) begin
      det5_ff <= {{(DETW-TW){term_ff[0][TW-1]}}, term_ff[0]}
               + {{(DETW-TW){term_ff[1][TW-1]}}, term_ff[1]}
               + {{(DETW-TW){term_ff[2][TW-1]}}, term_ff[2]};
      cof5_ff <= cof4_ff;
   end

   // stage 6: magnitudes and signs
   logic            v6_ff;
   logic [DETW-1:0] mag6_ff;
   logic            dneg6_ff;
   logic [CW-1:0]   cabs6_ff [0:8];
   logic            cneg6_ff [0:8];

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else       v6_ff <= v5_ff;
   end

   always_ff @(posedge clock) begin
      dneg6_ff <= det5_ff[DETW-1];
      mag6_ff  <= det5_ff[DETW-1] ? DETW'(-det5_ff) : DETW'(det5_ff);
   end

   for (genvar k = 0; k < 9; k++) begin : g_abs
      always_ff @(posedge clock) begin
         cneg6_ff[k] <= cof5_ff[k][CW-1];
         cabs6_ff[k] <= cof5_ff[k][CW-1] ? CW'(-cof5_ff[k]) : CW'(cof5_ff[k]);
      end
   end

   // stage 7: singular test on the rounded magnitude, lane words
   logic [DETW:0] rnd_mag;
   logic          sing_in;
   det_type       det_ff;
   lane_type      lane_ff [0:8];

   always_comb begin
      rnd_mag = ({1'b0, mag6_ff} + ((DETW+1)'(1) << (2*FB-1))) >> (2*FB);
      sing_in = (mag6_ff == '0) || (rnd_mag < (DETW+1)'(det_min));
   end

   always_ff @(posedge clock) begin
      if (reset) det_ff.valid <= 1'b0;
      else       det_ff.valid <= v6_ff;
   end

   always_ff @(posedge clock) begin
      det_ff.singular <= sing_in;
      det_ff.mag      <= mag6_ff;
   end

   for (genvar k = 0; k < 9; k++) begin : g_lane
      always_ff @(posedge clock) begin
         lane_ff[k].neg <= cneg6_ff[k] ^ dneg6_ff;
         lane_ff[k].num <= {cabs6_ff[k], {(2*FB){1'b0}}};
      end
   end

   assign det_out  = det_ff;
   assign lane_out = lane_ff;

endmodule

`default_nettype wire

[sv/mi3_div_lane.sv]
// ----------------------------------------------------------------------------
// mi3_div_lane: pipelined restoring divider for one inverse element
// One range check stage, one stage per quotient bit, then saturation,
// sign and the zeroing of singular items.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_div_lane
   import mi3_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire det_type  det_in,
   input  wire lane_type lane_in,
   output lane_out_type  res_out
);

   div_type st_ff [0:QB];

   // range check: quotient would need more than QB bits
   always_ff @(posedge clock) begin
      if (reset) st_ff[0].valid <= 1'b0;
      else       st_ff[0].valid <= det_in.valid;
   end

   always_ff @(posedge clock) begin
      st_ff[0].singular <= det_in.singular;
      st_ff[0].neg      <= lane_in.neg;
      st_ff[0].ovf      <= RW'(lane_in.num) >= (RW'(det_in.mag) << QB);
      st_ff[0].mag      <= det_in.mag;
      st_ff[0].rem      <= RW'(lane_in.num);
      st_ff[0].quo      <= '0;
   end

   // one quotient bit per stage, most significant first
   for (genvar i = 1; i <= QB; i++) begin : g_step
      localparam int BIT = QB - i;
      logic [RW-1:0] dsh;
      logic          take;

      always_comb begin
         dsh  = RW'(st_ff[i-1].mag) << BIT;
         take = st_ff[i-1].rem >= dsh;
      end

      always_ff @(posedge clock) begin
         if (reset) st_ff[i].valid <= 1'b0;
         else       st_ff[i].valid <= st_ff[i-1].valid;
      end

      always_ff @(posedge clock) begin
         st_ff[i].singular <= st_ff[i-1].singular;
         st_ff[i].neg      <= st_ff[i-1].neg;
         st_ff[i].ovf      <= st_ff[i-1].ovf;
         st_ff[i].mag      <= st_ff[i-1].mag;
         st_ff[i].rem      <= take ? st_ff[i-1].rem - dsh : st_ff[i-1].rem;
         st_ff[i].quo      <= st_ff[i-1].quo | (take ? (QB'(1) << BIT) : QB'(0));
      end
   end

   // saturate, apply sign, clear singular items
   localparam logic [QB-1:0] LIM = QB'(1) << (DW - 1);

   div_type       fin;
   logic [QB-1:0] quo_neg;
   logic          sat_in;
   logic [DW-1:0] val_in;
   lane_out_type  res_ff;

   always_comb begin
      fin     = st_ff[QB];
      quo_neg = QB'(0) - fin.quo;
      if (fin.neg) begin
         sat_in = fin.ovf || (fin.quo > LIM);
         val_in = sat_in ? {1'b1, {(DW-1){1'b0}}} : quo_neg[DW-1:0];
      end else begin
         sat_in = fin.ovf || (fin.quo >= LIM);
         val_in = sat_in ? {1'b0, {(DW-1){1'b1}}} : fin.quo[DW-1:0];
      end
      if (fin.singular) begin
         sat_in = 1'b0;
         val_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) res_ff.valid <= 1'b0;
      else       res_ff.valid <= fin.valid;
   end

   always_ff @(posedge clock) begin
      res_ff.singular <= fin.singular;
      res_ff.sat      <= sat_in;
      res_ff.value    <= val_in;
   end

   assign res_out = res_ff;

endmodule

`default_nettype wire

[sv/matrix3_inverse.sv]
// Throughput: one matrix per cycle; busy is always low, the pipeline never stalls.
// Latency is set mostly by the restoring divider with its 33 quotient-bit stages, one quotient bit per stage.
// Reset: synchronous, clears all valid bits and sets det_minimum to 1.
// ----------------------------------------------------------------------------
// matrix3_inverse: 3x3 Q16.16 matrix inverse by the adjugate
// Exact cofactors and determinant, singular test against det_minimum, nine
// pipelined dividers with saturation to the signed element range.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix3_inverse
   import mi3_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);

   // configuration register
   logic [31:0] det_min_ff;

   always_ff @(posedge clock) begin
      if (reset)                       det_min_ff <= 32'd1;
      else if (csr_valid && csr_ready) det_min_ff <= csr_data;
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // front end
   det_type  det_w;
   lane_type lane_w [0:8];

   mi3_det u_det (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .in_data  (req_data),
      .det_min  (det_min_ff),
      .det_out  (det_w),
      .lane_out (lane_w)
   );

   // divider lanes, one per inverse element
   lane_out_type res_w [0:8];

   for (genvar k = 0; k < 9; k++) begin : g_div
      mi3_div_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .det_in  (det_w),
         .lane_in (lane_w[k]),
         .res_out (res_w[k])
      );
   end

   // output word
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= res_w[0].valid;
   end

   always_ff @(posedge clock) begin
      rsp_ff.inv00     <= res_w[0].value;
      rsp_ff.inv01     <= res_w[1].value;
      rsp_ff.inv02     <= res_w[2].value;
      rsp_ff.inv10     <= res_w[3].value;
      rsp_ff.inv11     <= res_w[4].value;
      rsp_ff.inv12     <= res_w[5].value;
      rsp_ff.inv20     <= res_w[6].value;
      rsp_ff.inv21     <= res_w[7].value;
      rsp_ff.inv22     <= res_w[8].value;
      rsp_ff.singular  <= res_w[0].singular;
      rsp_ff.saturated <= res_w[0].sat | res_w[1].sat | res_w[2].sat
                        | res_w[3].sat | res_w[4].sat | res_w[5].sat
                        | res_w[6].sat | res_w[7].sat | res_w[8].sat;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[tb/sv/tb_matrix3_inverse.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix3_inverse: self-checking testbench of the 3x3 matrix inverse
// Drives directed and random matrices with random start gaps, predicts each
// inverse with exact wide integer arithmetic, and checks every result word
// field by field in order. det_minimum is rewritten between drained phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_matrix3_inverse
   import mi3_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 60;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;

   matrix3_inverse DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   req_type     matrix_queue[$];
   rsp_type     inverse_queue[$];
   logic [31:0] det_min_copy = 32'd1;
   bit          word_taken = 1'b0;
   bit          quiet_tail = 1'b0;
   int          gap_left = 0;
   int          mismatches = 0;
   int          sent_count = 0;
   int          got_count = 0;
   int          singular_count = 0;
   int          saturated_count = 0;
   int          stall_cycles = 0;

   // exact inverse of one matrix by the adjugate
   function automatic rsp_type inverse_of(req_type m, logic [31:0] dmin);
      logic signed [127:0] e[9];
      logic signed [127:0] c[9];
      logic signed [127:0] det;
      logic [127:0]        mag, rnd, num, q;
      logic [31:0]         v;
      bit                  neg, sat;
      rsp_type             r;
      sat = 1'b0;
      r = '0;
      for (int i = 0; i < 9; i++) e[i] = $signed(m[(8-i)*32 +: 32]);
      det = e[0]*e[4]*e[8] + e[1]*e[5]*e[6] + e[3]*e[7]*e[2]
          - e[6]*e[4]*e[2] - e[7]*e[5]*e[0] - e[1]*e[3]*e[8];
      mag = (det < 0) ? -det : det;
      // magnitude rounded to Q16.16, halves away from zero
      rnd = (mag + (128'd1 << 31)) >> 32;
      if (det == 0 || rnd < {96'd0, dmin}) begin
         r.singular = 1'b1;
         return r;
      end
      c[0] = e[4]*e[8] - e[7]*e[5];
      c[1] = e[7]*e[2] - e[1]*e[8];
      c[2] = e[1]*e[5] - e[4]*e[2];
      c[3] = e[6]*e[5] - e[3]*e[8];
      c[4] = e[0]*e[8] - e[6]*e[2];
      c[5] = e[3]*e[2] - e[0]*e[5];
      c[6] = e[3]*e[7] - e[6]*e[4];
      c[7] = e[6]*e[1] - e[0]*e[7];
      c[8] = e[0]*e[4] - e[3]*e[1];
      for (int i = 0; i < 9; i++) begin
         neg = (c[i] < 0) != (det < 0);
         num = ((c[i] < 0) ? -c[i] : c[i]) << 32;
         q = num / mag;
         if (!neg && q >= (128'd1 << 31)) begin
            sat = 1'b1;
            q = (128'd1 << 31) - 1;
         end else if (neg && q > (128'd1 << 31)) begin
            sat = 1'b1;
            q = 128'd1 << 31;
         end
         v = neg ? -q[31:0] : q[31:0];
         r[(8-i)*32+2 +: 32] = v;
      end
      r.saturated = sat;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on word %0d, %s: expected %h, got %h",
                     got_count, name, want, got);
      end
   endfunction

   // monitor: sample handshakes, predict accepted matrices, check results
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) det_min_copy = csr_data;
         if (start && !busy) begin
            inverse_queue.push_back(inverse_of(req_data, det_min_copy));
            word_taken = 1'b1;
            sent_count++;
         end
         if (rsp_valid) begin
            if (inverse_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("result word with none expected");
            end else begin
               want = inverse_queue.pop_front();
               for (int i = 0; i < 9; i++)
                  check_field($sformatf("inv%0d%0d", i / 3, i % 3),
                              want[(8-i)*32+2 +: 32], rsp_data[(8-i)*32+2 +: 32]);
               check_field("singular", want.singular, rsp_data.singular);
               check_field("saturated", want.saturated, rsp_data.saturated);
               singular_count += rsp_data.singular;
               saturated_count += rsp_data.saturated;
            end
            got_count++;
         end
         // watchdog on cycles without any handshake
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout waiting for a handshake");
            $display("tb_matrix3_inverse failed");
            $finish;
         end
      end
   end

   // driver: present queued matrices with random gaps
   always @(negedge clock) begin
      if (word_taken) begin
         void'(matrix_queue.pop_front());
         word_taken = 1'b0;
         if (!quiet_tail && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 8);
      end
      if (reset) begin
         start <= 1'b0;
      end else if (gap_left > 0) begin
         gap_left--;
         start <= 1'b0;
      end else if (matrix_queue.size() > 0) begin
         start <= 1'b1;
         req_data <= matrix_queue[0];
      end else begin
         start <= 1'b0;
      end
   end

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(0, 6))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'h0001_0000;
         4: return 32'hffff_0000;
         5: return 32'h0000_0001;
         default: return 32'hffff_ffff;
      endcase
   endfunction

   function automatic logic [31:0] small_elem(int range);
      int v;
      v = $urandom_range(0, 2 * range) - range;
      return v;
   endfunction

   task automatic push_matrix(input logic [31:0] v[9]);
      req_type m;
      for (int i = 0; i < 9; i++) m[(8-i)*32 +: 32] = v[i];
      matrix_queue.push_back(m);
   endtask

   task automatic push_diag(input logic [31:0] d0, d1, d2);
      logic [31:0] v[9];
      v = '{d0, 0, 0, 0, d1, 0, 0, 0, d2};
      push_matrix(v);
   endtask

   // random matrix in one of several shapes
   task automatic push_random();
      logic [31:0] v[9];
      int mode;
      mode = $urandom_range(0, 19);
      for (int i = 0; i < 9; i++) begin
         if (mode < 2) v[i] = $urandom();
         else if (mode < 10) v[i] = small_elem(8 << 16);
         else if (mode < 13) v[i] = small_elem($urandom_range(1, 1024));
         else if (mode < 15) v[i] = pick_extreme();
         else if (mode < 17) v[i] = (i % 4 == 0) ? $urandom() : small_elem(256);
         else v[i] = small_elem(4 << 16);
      end
      // exactly dependent rows
      if (mode >= 17) for (int j = 0; j < 3; j++) v[6+j] = v[j] + v[3+j];
      push_matrix(v);
   endtask

   task automatic drain();
      wait (matrix_queue.size() == 0 && inverse_queue.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_det_min(input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [31:0] v[9];
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: identity, zero, extremes, rounding edges, overflow
      push_diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      push_diag(0, 0, 0);
      v = '{default: 32'h7fff_ffff};
      push_matrix(v);
      v = '{default: 32'h8000_0000};
      push_matrix(v);
      push_diag(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      push_diag(32'h0002_0000, 32'h0000_8000, 32'hfffe_0000);
      push_diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
      push_diag(32'h0000_8000, 32'h0000_8000, 32'h0000_0002);
      push_diag(32'h0000_8000, 32'h0000_8000, 32'h0000_0001);
      push_diag(32'h7fff_ffff, 32'h0000_0001, 32'h0000_0001);
      push_diag(32'h0000_0002, 32'h0001_0000, 32'h0001_0000);
      push_diag(32'hffff_fffe, 32'h0001_0000, 32'h0001_0000);
      push_diag(32'hffff_ffff, 32'h0001_0000, 32'h0001_0000);
      push_diag(32'h0000_0100, 32'h0001_0000, 32'hffff_ff00);
      v = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
            32'h0000_0000, 32'h0001_0000, 32'h0004_0000,
            32'h0005_0000, 32'h0006_0000, 32'h0000_0000};
      push_matrix(v);
      v = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
            32'h0004_0000, 32'h0005_0000, 32'h0006_0000,
            32'h0007_0000, 32'h0008_0000, 32'h0009_0000};
      push_matrix(v);
      drain();

      // zero threshold: only an exact zero determinant is singular
      write_det_min(32'd0);
      push_diag(32'h0000_8000, 32'h0000_8000, 32'h0000_0001);
      push_diag(0, 32'h0001_0000, 32'h0001_0000);
      for (int n = 0; n < 400; n++) push_random();
      drain();

      // threshold of 1.0
      write_det_min(32'h0001_0000);
      for (int n = 0; n < 400; n++) push_random();
      drain();

      // largest threshold
      write_det_min(32'hffff_ffff);
      for (int n = 0; n < 150; n++) push_random();
      drain();

      // random threshold, last part without gaps
      write_det_min($urandom_range(1, 32'h0004_0000));
      for (int n = 0; n < 400; n++) push_random();
      wait (matrix_queue.size() < 150);
      quiet_tail = 1'b1;
      for (int n = 0; n < 180; n++) push_random();
      drain();

      $display("%0d matrices sent, %0d results checked (%0d singular, %0d saturated)",
               sent_count, got_count, singular_count, saturated_count);
      $display("det_minimum swept over 1, 0, 1.0, max and a random value");
      if (mismatches == 0 && inverse_queue.size() == 0) begin
         $display("tb_matrix3_inverse passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_matrix3_inverse failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
